@@ rtl/acrp_pkg.sv @@
// Shared types, constants and the hex digit decoder of the ASCII register command parser.
`timescale 1ns / 1ps
package acrp_pkg;

   localparam int NUM_REGS = 256;
   localparam int ADDR_W   = 8;
   localparam int DATA_W   = 16;

   // Characters of the command syntax.
   localparam logic [7:0] CR_BYTE = 8'h0D;
   localparam logic [7:0] CH_W_UP = 8'h57;
   localparam logic [7:0] CH_W_LO = 8'h77;
   localparam logic [7:0] CH_R_UP = 8'h52;
   localparam logic [7:0] CH_R_LO = 8'h72;
   localparam logic [7:0] CH_V_UP = 8'h56;
   localparam logic [7:0] CH_V_LO = 8'h76;

   // Operation codes of an input transaction.
   localparam logic [1:0] OP_SERIAL      = 2'd0;
   localparam logic [1:0] OP_LOCAL_WRITE = 2'd1;
   localparam logic [1:0] OP_LOCAL_READ  = 2'd2;

   // Result kinds.
   localparam logic [1:0] KIND_STATUS      = 2'd0;
   localparam logic [1:0] KIND_SERIAL_READ = 2'd1;
   localparam logic [1:0] KIND_LOCAL_READ  = 2'd2;

   // Status codes.
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BADFN    = 2'd1;
   localparam logic [1:0] ST_NOHEX    = 2'd2;
   localparam logic [1:0] ST_BADDELIM = 2'd3;

   typedef enum logic [3:0] {
      PS_START,
      PS_WADDR1,
      PS_WADDR2,
      PS_WDELIM,
      PS_DATA1,
      PS_DATA2,
      PS_DATA3,
      PS_DATA4,
      PS_RADDR1,
      PS_RADDR2,
      PS_ERROR,
      PS_DONE
   } parse_state_type;

   // Register file access requested by one transaction.
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [DATA_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } rf_cmd_type;

   // Result produced by one transaction, data excepted.
   typedef struct packed {
      logic              valid;
      logic [1:0]        kind;
      logic [1:0]        status;
      logic [ADDR_W-1:0] addr;
   } res_info_type;

   // Returns {is_hex, nibble} for an ASCII character.
   function automatic logic [4:0] hex_decode(input logic [7:0] b);
      logic       hit;
      logic [3:0] nib;
      hit = 1'b0;
      nib = 4'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         hit = 1'b1;
         nib = b[3:0];
      end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
         hit = 1'b1;
         nib = b[3:0] + 4'd9;
      end
      return {hit, nib};
   endfunction

endpackage

@@ rtl/acrp_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
module acrp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/acrp_regfile.sv @@
// Register file: RAM storage plus per-entry valid bits so that reset reads as zero.
`timescale 1ns / 1ps
module acrp_regfile
   import acrp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  rf_cmd_type        cmd,
   output logic [DATA_W-1:0] rd_data
);

   logic [NUM_REGS-1:0] vld_ff;
   logic [NUM_REGS-1:0] vld_in;
   logic                hit_ff;
   logic                hit_in;
   logic [DATA_W-1:0]   ram_rd_data;

   acrp_ram #(
      .WIDTH (DATA_W),
      .DEPTH (NUM_REGS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (cmd.wr_addr),
      .wr_data (cmd.wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      vld_in = vld_ff;
      if (cmd.wr_en) begin
         vld_in[cmd.wr_addr] = 1'b1;
      end
      hit_in = cmd.rd_en ? vld_ff[cmd.rd_addr] : hit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         hit_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
         hit_ff <= hit_in;
      end
   end

   // An entry never written since reset reads as zero.
   assign rd_data = hit_ff ? ram_rd_data : '0;

endmodule

@@ rtl/acrp_parser.sv @@
// Command parser state machine and address and data accumulators.
`timescale 1ns / 1ps
module acrp_parser
   import acrp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  logic [1:0]        op,
   input  logic [7:0]        rx_byte,
   input  logic [ADDR_W-1:0] local_address,
   input  logic [DATA_W-1:0] local_data,
   output rf_cmd_type        rf_cmd,
   output res_info_type      res
);

   parse_state_type   state_ff;
   parse_state_type   state_in;
   logic [ADDR_W-1:0] addr_accum_ff;
   logic [ADDR_W-1:0] addr_accum_in;
   logic [DATA_W-1:0] data_accum_ff;
   logic [DATA_W-1:0] data_accum_in;
   logic [4:0]        hex_dec;
   logic              is_hex;
   logic [3:0]        nib;
   logic              serial;
   logic              is_cr;
   logic [ADDR_W-1:0] addr_shift;
   logic [DATA_W-1:0] data_shift;

   assign hex_dec    = hex_decode(rx_byte);
   assign is_hex     = hex_dec[4];
   assign nib        = hex_dec[3:0];
   assign serial     = fire && (op == OP_SERIAL);
   assign is_cr      = (rx_byte == CR_BYTE);
   assign addr_shift = {addr_accum_ff[ADDR_W-5:0], nib};
   assign data_shift = {data_accum_ff[DATA_W-5:0], nib};

   // Next state.
   always_comb begin
      state_in = state_ff;
      if (serial) begin
         if (is_cr) begin
            state_in = PS_START;
         end else begin
            unique case (state_ff)
               PS_START: begin
                  if (rx_byte == CH_W_UP || rx_byte == CH_W_LO) begin
                     state_in = PS_WADDR1;
                  end else if (rx_byte == CH_R_UP || rx_byte == CH_R_LO) begin
                     state_in = PS_RADDR1;
                  end else begin
                     state_in = PS_ERROR;
                  end
               end
               PS_WADDR1: state_in = is_hex ? PS_WADDR2 : PS_ERROR;
               PS_WADDR2: state_in = is_hex ? PS_WDELIM : PS_ERROR;
               PS_WDELIM: begin
                  state_in = (rx_byte == CH_V_UP || rx_byte == CH_V_LO) ? PS_DATA1 : PS_ERROR;
               end
               PS_DATA1:  state_in = is_hex ? PS_DATA2 : PS_ERROR;
               PS_DATA2:  state_in = is_hex ? PS_DATA3 : PS_ERROR;
               PS_DATA3:  state_in = is_hex ? PS_DATA4 : PS_ERROR;
               PS_DATA4:  state_in = is_hex ? PS_DONE : PS_ERROR;
               PS_RADDR1: state_in = is_hex ? PS_RADDR2 : PS_ERROR;
               PS_RADDR2: state_in = is_hex ? PS_DONE : PS_ERROR;
               PS_ERROR:  state_in = PS_ERROR;
               PS_DONE:   state_in = PS_DONE;
               default:   state_in = state_ff;
            endcase
         end
      end
   end

   // Accumulators, register file access and result.
   always_comb begin
      addr_accum_in = addr_accum_ff;
      data_accum_in = data_accum_ff;
      rf_cmd        = '0;
      res           = '0;
      if (fire) begin
         unique case (op)
            OP_SERIAL: begin
               if (!is_cr) begin
                  unique case (state_ff)
                     PS_START: begin
                        if (!(rx_byte == CH_W_UP || rx_byte == CH_W_LO ||
                              rx_byte == CH_R_UP || rx_byte == CH_R_LO)) begin
                           res.valid  = 1'b1;
                           res.kind   = KIND_STATUS;
                           res.status = ST_BADFN;
                        end
                     end
                     PS_WADDR1, PS_RADDR1: begin
                        if (is_hex) begin
                           addr_accum_in = {{(ADDR_W-4){1'b0}}, nib};
                        end
                     end
                     PS_WADDR2: begin
                        if (is_hex) begin
                           addr_accum_in = addr_shift;
                        end
                     end
                     PS_WDELIM: begin
                        if (!(rx_byte == CH_V_UP || rx_byte == CH_V_LO)) begin
                           res.valid  = 1'b1;
                           res.kind   = KIND_STATUS;
                           res.status = ST_BADDELIM;
                        end
                     end
                     PS_DATA1: begin
                        if (is_hex) begin
                           data_accum_in = {{(DATA_W-4){1'b0}}, nib};
                        end
                     end
                     PS_DATA2, PS_DATA3: begin
                        if (is_hex) begin
                           data_accum_in = data_shift;
                        end
                     end
                     PS_DATA4: begin
                        if (is_hex) begin
                           data_accum_in  = data_shift;
                           rf_cmd.wr_en   = 1'b1;
                           rf_cmd.wr_addr = addr_accum_ff;
                           rf_cmd.wr_data = data_shift;
                           res.valid      = 1'b1;
                           res.kind       = KIND_STATUS;
                           res.status     = ST_OK;
                        end
                     end
                     PS_RADDR2: begin
                        if (is_hex) begin
                           addr_accum_in  = addr_shift;
                           rf_cmd.rd_en   = 1'b1;
                           rf_cmd.rd_addr = addr_shift;
                           res.valid      = 1'b1;
                           res.kind       = KIND_SERIAL_READ;
                           res.status     = ST_OK;
                           res.addr       = addr_shift;
                        end
                     end
                     default: begin
                     end
                  endcase
                  // Every digit position reports a non-hex character the same way.
                  if (!is_hex && (state_ff == PS_WADDR1 || state_ff == PS_WADDR2 ||
                                  state_ff == PS_DATA1 || state_ff == PS_DATA2 ||
                                  state_ff == PS_DATA3 || state_ff == PS_DATA4 ||
                                  state_ff == PS_RADDR1 || state_ff == PS_RADDR2)) begin
                     res.valid  = 1'b1;
                     res.kind   = KIND_STATUS;
                     res.status = ST_NOHEX;
                  end
               end
            end
            OP_LOCAL_WRITE: begin
               rf_cmd.wr_en   = 1'b1;
               rf_cmd.wr_addr = local_address;
               rf_cmd.wr_data = local_data;
            end
            OP_LOCAL_READ: begin
               rf_cmd.rd_en   = 1'b1;
               rf_cmd.rd_addr = local_address;
               res.valid      = 1'b1;
               res.kind       = KIND_LOCAL_READ;
               res.status     = ST_OK;
               res.addr       = local_address;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= PS_START;
         addr_accum_ff <= '0;
         data_accum_ff <= '0;
      end else begin
         state_ff      <= state_in;
         addr_accum_ff <= addr_accum_in;
         data_accum_ff <= data_accum_in;
      end
   end

endmodule

@@ rtl/ascii_register_command_parser_unit.sv @@
// Top level of the ASCII register command parser: handshakes, result pipeline and output register.
`timescale 1ns / 1ps
// Usage
// The request channel carries one transaction per accepted item: a received serial byte
// (req_op 0), a local register write (1) or a local register read (2). Serial bytes are
// parsed as 'W' aa 'V' dddd or 'R' aa commands against 256 16-bit registers; a carriage
// return restarts parsing. The response channel returns status reports, serial read
// responses and local read data, one response for each transaction that produces one.
// Throughput is one transaction per cycle while the receiver does not stall. A response
// passes the parser and the register file read, whose data comes from a RAM with registered
// read, into the middle stage, and from there into the output register that drives rsp_valid.
// Transactions that produce no response (local writes, bytes inside a command, ignored
// bytes) simply pass through the parser.
// Reset returns the parser to its start state and clears the accumulators and the valid
// bit of every register, so all registers read as zero until written; no clearing pass
// is needed. When the receiver stalls, the output register holds its response and the
// middle stage holds the next one; req_ready falls only when both are occupied.
module ascii_register_command_parser_unit
   import acrp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_op,
   input  logic [7:0]        req_rx_byte,
   input  logic [ADDR_W-1:0] req_local_address,
   input  logic [DATA_W-1:0] req_local_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_kind,
   output logic [1:0]        rsp_status_code,
   output logic [ADDR_W-1:0] rsp_reg_address,
   output logic [DATA_W-1:0] rsp_reg_data
);

   logic              fire;
   logic              s1_move;
   rf_cmd_type        rf_cmd;
   res_info_type      res;
   logic [DATA_W-1:0] rf_rd_data;

   // Middle stage: result information waiting beside the registered RAM read data.
   logic              s1_valid_ff;
   logic              s1_valid_in;
   logic [1:0]        s1_kind_ff;
   logic [1:0]        s1_status_ff;
   logic [ADDR_W-1:0] s1_addr_ff;

   // Output register.
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [1:0]        rsp_kind_ff;
   logic [1:0]        rsp_status_ff;
   logic [ADDR_W-1:0] rsp_addr_ff;
   logic [DATA_W-1:0] rsp_data_ff;

   // The middle stage may advance whenever the output register is empty or being emptied.
   assign s1_move   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || s1_move;
   assign fire      = req_valid && req_ready;

   acrp_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .op            (req_op),
      .rx_byte       (req_rx_byte),
      .local_address (req_local_address),
      .local_data    (req_local_data),
      .rf_cmd        (rf_cmd),
      .res           (res)
   );

   // The read data register only updates on an accepted read, so it holds while the
   // middle stage is stalled.
   acrp_regfile u_regfile (
      .clock   (clock),
      .reset   (reset),
      .cmd     (rf_cmd),
      .rd_data (rf_rd_data)
   );

   always_comb begin
      if (fire) begin
         s1_valid_in = res.valid;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (s1_move) begin
         rsp_valid_in = s1_valid_ff;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         s1_kind_ff   <= res.kind;
         s1_status_ff <= res.status;
         s1_addr_ff   <= res.addr;
      end
      if (s1_move && s1_valid_ff) begin
         rsp_kind_ff   <= s1_kind_ff;
         rsp_status_ff <= s1_status_ff;
         rsp_addr_ff   <= s1_addr_ff;
         // Status reports carry no register contents.
         rsp_data_ff   <= (s1_kind_ff == KIND_STATUS) ? '0 : rf_rd_data;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_status_code = rsp_status_ff;
   assign rsp_reg_address = rsp_addr_ff;
   assign rsp_reg_data    = rsp_data_ff;

   // Back-pressure only arises when both result stages are occupied.
   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && rsp_valid_ff && !rsp_ready))
      else $error("request side stalled with a free result stage");

   // A stalled output register keeps the middle stage occupied.
   a_mid_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_ready) |=> s1_valid_ff)
      else $error("middle stage result lost during a stall");

   // Status reports carry zero address and data.
   a_status_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == KIND_STATUS) |->
         (rsp_addr_ff == '0 && rsp_data_ff == '0))
      else $error("status report with non-zero address or data");

   // Read responses always report status ok.
   a_read_status_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff == KIND_SERIAL_READ || rsp_kind_ff == KIND_LOCAL_READ))
         |-> (rsp_status_ff == ST_OK))
      else $error("read response with an error status");

endmodule
